### src/lss_pkg.sv
// Shared types and codes for the LIFO stack with search.
package lss_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam int OP_W     = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd2;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [WORD_W-1:0] data_value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] word_out;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         element_count;
    logic                     last;
  } out_t;

endpackage

### src/lss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold the last read word while not reading
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/lss_ctrl.sv
// Sequencer for the stack: fill level, scan counter and the search word compare.
module lss_ctrl #(
  parameter int STACK_DEPTH = lss_pkg::STACK_DEPTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  lss_pkg::in_t                                  in_data,
  output logic                                          res_valid,
  input  logic                                          res_ready,
  output lss_pkg::out_t                                 res,
  output logic                                          ram_we,
  output logic [((STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1)-1:0] ram_waddr,
  output logic [lss_pkg::WORD_W-1:0]                    ram_wdata,
  output logic                                          ram_re,
  output logic [((STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1)-1:0] ram_raddr,
  input  logic [lss_pkg::WORD_W-1:0]                    ram_rdata
);

  import lss_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      idx_r, idx_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [WORD_W-1:0]  key_r, key_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [FW-1:0]      pend_pos_r, pend_pos_nxt;
  out_t               res_r, res_nxt;

  logic [FW-1:0]      idx_inc;
  logic               last_entry;
  logic               match;
  logic [AW-1:0]      top_addr;
  logic [AW-1:0]      adv_addr;
  logic [POS_W-1:0]   pos_out;

  assign idx_inc    = idx_r + FW'(1);
  assign last_entry = (idx_r == fill_r - FW'(1));
  assign match      = (ram_rdata == key_r);
  assign pos_out    = POS_W'(idx_inc);
  assign top_addr   = AW'(fill_r - FW'(1));
  assign adv_addr   = AW'(fill_r - idx_inc - FW'(1));

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    idx_nxt      = idx_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    pend_v_nxt   = pend_v_r;
    pend_pos_nxt = pend_pos_r;
    res_nxt      = res_r;
    in_ready     = (state_r == S_IDLE);
    res_valid    = 1'b0;
    res          = '0;
    ram_we       = 1'b0;
    ram_waddr    = AW'(fill_r);
    ram_wdata    = in_data.data_value;
    ram_re       = 1'b0;
    ram_raddr    = top_addr;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.opcode;
          key_nxt      = in_data.data_value;
          idx_nxt      = '0;
          pend_v_nxt   = 1'b0;
          pend_pos_nxt = '0;
          priority if (in_data.opcode == OP_PUSH) begin
            if (fill_r == FW'(STACK_DEPTH)) begin
              res_nxt = '{status: ST_FULL, word_out: '0, position: '0,
                          element_count: '0, last: 1'b1};
            end else begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + FW'(1);
              res_nxt  = '{status: ST_OK, word_out: '0, position: '0,
                           element_count: '0, last: 1'b1};
            end
            state_nxt = S_EMIT;
          end else if (in_data.opcode > OP_SEARCH) begin
            // unused opcode: drop the beat
            state_nxt = S_IDLE;
          end else if (fill_r == '0) begin
            res_nxt = '{status: ST_EMPTY, word_out: '0, position: '0,
                        element_count: '0, last: 1'b1};
            state_nxt = S_EMIT;
          end else if (in_data.opcode == OP_COUNT) begin
            res_nxt = '{status: ST_OK, word_out: '0, position: '0,
                        element_count: POS_W'(fill_r), last: 1'b1};
            state_nxt = S_EMIT;
          end else begin
            // pop, list and search start by reading the top entry
            ram_re = 1'b1;
            if (in_data.opcode == OP_POP) begin
              fill_nxt = fill_r - FW'(1);
            end
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        priority if (op_r == OP_POP) begin
          res_valid = 1'b1;
          res = '{status: ST_OK, word_out: ram_rdata, position: '0,
                  element_count: '0, last: 1'b1};
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end else if (op_r == OP_LIST) begin
          res_valid = 1'b1;
          res = '{status: ST_OK, word_out: ram_rdata, position: pos_out,
                  element_count: '0, last: last_entry};
          if (res_ready) begin
            if (last_entry) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt   = idx_inc;
              ram_re    = 1'b1;
              ram_raddr = adv_addr;
            end
          end
        end else begin
          // search: a match is held back until the next one shows it is not the last
          res_valid = match && pend_v_r;
          res = '{status: ST_OK, word_out: key_r, position: POS_W'(pend_pos_r),
                  element_count: '0, last: 1'b0};
          if (!res_valid || res_ready) begin
            if (match) begin
              pend_v_nxt   = 1'b1;
              pend_pos_nxt = idx_inc;
            end
            if (last_entry) begin
              if (match || pend_v_r) begin
                res_nxt = '{status: ST_OK, word_out: key_r,
                            position: match ? pos_out : POS_W'(pend_pos_r),
                            element_count: '0, last: 1'b1};
              end else begin
                res_nxt = '{status: ST_NOTFOUND, word_out: '0, position: '0,
                            element_count: '0, last: 1'b1};
              end
              state_nxt = S_EMIT;
            end else begin
              idx_nxt   = idx_inc;
              ram_re    = 1'b1;
              ram_raddr = adv_addr;
            end
          end
        end
      end

      S_EMIT: begin
        res_valid = 1'b1;
        res       = res_r;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    pend_pos_r <= pend_pos_nxt;
    res_r      <= res_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(STACK_DEPTH))
    else $error("fill level beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode == OP_PUSH && fill_r != FW'(STACK_DEPTH))
    |=> (fill_r == $past(fill_r) + FW'(1)))
    else $error("accepted push did not grow the stack");

  // pop has already lowered the fill level while its word is presented
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && op_r != OP_POP) |-> (idx_r < fill_r))
    else $error("scan index past fill level");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && res.last) |=> (state_r == S_IDLE))
    else $error("final beat did not end the operation");

endmodule

### src/lifo_stack_with_search_core.sv
// LIFO stack with search: top level with the word RAM and the result register.
//
// A bounded LIFO of signed 32-bit words taking push, pop, list, count and search
// commands, one at a time. in_ready is high only while no command is in progress.
// Push, count and commands on an empty stack are staged in the controller's holding
// register before the result register; pop reads the top word from the RAM for its beat.
// List and search walk the stored words from the top through the single RAM read
// port, one word per cycle while the result register can take each beat; search's
// final beat passes through one holding register. List returns one beat per word;
// search returns one beat per match (position counted from 1 at the top) or a
// single not-found beat. The final beat of every command carries last. Opcodes
// 5 to 7 are dropped without a result.
module lifo_stack_with_search_core #(
  parameter int STACK_DEPTH = lss_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lss_pkg::out_t out_data
);

  import lss_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic              res_valid;
  logic              res_ready;
  out_t              res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  lss_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // load a new beat when the register is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/tb.sv
// Testbench for lifo_stack_with_search_core: queued traffic, stack predictor, beat checker.
`timescale 1ns / 100ps

module tb;
  import lss_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_SEARCH + 3'd1;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  in_t  pending_cmds[$];
  out_t expected_beats[$];

  logic signed [WORD_W-1:0] stack_words[DEPTH];
  int stack_fill = 0;

  int gen_fill     = 0;
  int valid_queued = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_trigger = 1'b0;
  int hold_left      = 0;
  int err_cnt        = 0;
  int cycle_cnt      = 0;

  lifo_stack_with_search_core #(.STACK_DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Work out the beats one accepted command causes and advance the stack copy.
  task automatic predict_stack_op(input in_t cmd);
    out_t beat;
    int hits;
    beat = '0;
    beat.last = 1'b1;
    hits = 0;
    if (cmd.opcode > OP_SEARCH) return;
    if (cmd.opcode == OP_PUSH) begin
      if (stack_fill >= DEPTH) begin
        beat.status = ST_FULL;
      end else begin
        stack_words[stack_fill] = cmd.data_value;
        stack_fill++;
        beat.status = ST_OK;
      end
      expected_beats.push_back(beat);
    end else if (stack_fill == 0) begin
      beat.status = ST_EMPTY;
      expected_beats.push_back(beat);
    end else begin
      case (cmd.opcode)
        OP_POP: begin
          stack_fill--;
          beat.status   = ST_OK;
          beat.word_out = stack_words[stack_fill];
          expected_beats.push_back(beat);
        end
        OP_LIST: begin
          for (int i = 0; i < stack_fill; i++) begin
            beat.status   = ST_OK;
            beat.word_out = stack_words[stack_fill - 1 - i];
            beat.position = POS_W'(i + 1);
            beat.last     = (i == stack_fill - 1);
            expected_beats.push_back(beat);
          end
        end
        OP_COUNT: begin
          beat.status        = ST_OK;
          beat.element_count = POS_W'(stack_fill);
          expected_beats.push_back(beat);
        end
        default: begin
          for (int i = 0; i < stack_fill; i++) begin
            if (stack_words[stack_fill - 1 - i] == cmd.data_value) begin
              beat.status   = ST_OK;
              beat.word_out = cmd.data_value;
              beat.position = POS_W'(i + 1);
              beat.last     = 1'b0;
              expected_beats.push_back(beat);
              hits++;
            end
          end
          if (hits == 0) begin
            beat.status = ST_NOTFOUND;
            expected_beats.push_back(beat);
          end else begin
            expected_beats[expected_beats.size() - 1].last = 1'b1;
          end
        end
      endcase
    end
  endtask

  // Driver: present the next pending command, hold it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_stack_op(in_data);
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_data  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_trigger) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor: check each result beat against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected beat: status %0d word %0d pos %0d count %0d last %0b",
                     out_data.status, out_data.word_out, out_data.position,
                     out_data.element_count, out_data.last);
        end else begin
          want = expected_beats.pop_front();
          if (out_data.status !== want.status || out_data.word_out !== want.word_out ||
              out_data.position !== want.position ||
              out_data.element_count !== want.element_count ||
              out_data.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("mismatch exp: status %0d word %0d pos %0d count %0d last %0b",
                       want.status, want.word_out, want.position,
                       want.element_count, want.last);
              $display("         got: status %0d word %0d pos %0d count %0d last %0b",
                       out_data.status, out_data.word_out, out_data.position,
                       out_data.element_count, out_data.last);
            end
          end
        end
      end
      out_ready <= (hold_left == 0) && !hold_trigger &&
                   ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("lifo_stack_with_search_core verification failed");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] val);
    in_t cmd;
    cmd.opcode     = op;
    cmd.data_value = val;
    pending_cmds.push_back(cmd);
    if (op <= OP_SEARCH) valid_queued++;
    if (op == OP_PUSH && gen_fill < DEPTH) gen_fill++;
    if (op == OP_POP && gen_fill > 0) gen_fill--;
  endtask

  // Draw from a small pool so that searches hit, often more than once.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(7, 0))
      0: return 32'sh0000_0000;
      1: return -32'sd1;
      2: return 32'sh7FFF_FFFF;
      3: return 32'sh8000_0000;
      4: return 32'sh55AA_55AA;
      5: return 32'sd7;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_traffic(input int n_valid);
    int goal;
    int roll;
    goal = valid_queued + n_valid;
    while (valid_queued < goal) begin
      roll = $urandom_range(9, 0);
      if (roll <= 1) begin
        // fill to the top, overflow, then walk the full stack
        while (gen_fill < DEPTH) queue_cmd(OP_PUSH, pick_word());
        repeat ($urandom_range(2, 1)) queue_cmd(OP_PUSH, $urandom);
        queue_cmd(OP_LIST, $urandom);
        queue_cmd(OP_SEARCH, pick_word());
        queue_cmd(OP_COUNT, $urandom);
      end else if (roll == 2) begin
        // drain to empty and underflow
        while (gen_fill > 0) queue_cmd(OP_POP, $urandom);
        queue_cmd(OP_POP, $urandom);
        queue_cmd($urandom_range(2, 0) == 0 ? OP_LIST :
                  ($urandom_range(1, 0) ? OP_SEARCH : OP_COUNT), pick_word());
      end else if (roll == 3) begin
        repeat (4) queue_cmd(OP_W'($urandom_range(7, 0)), $urandom);
        queue_cmd(OP_FIRST_UNUSED + OP_W'($urandom_range(2, 0)), $urandom);
      end else begin
        repeat (8) begin
          roll = $urandom_range(99, 0);
          if (roll < 35)      queue_cmd(OP_PUSH, pick_word());
          else if (roll < 55) queue_cmd(OP_POP, $urandom);
          else if (roll < 65) queue_cmd(OP_LIST, $urandom);
          else if (roll < 75) queue_cmd(OP_COUNT, $urandom);
          else                queue_cmd(OP_SEARCH, pick_word());
        end
      end
    end
  endtask

  // Hold the sender until the block has returned every expected beat.
  task automatic drain_all();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_beats.size() != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty stack, ignored opcodes, extremes, hits and misses
    queue_cmd(OP_POP, 32'sd0);
    queue_cmd(OP_LIST, 32'sd0);
    queue_cmd(OP_COUNT, 32'sd0);
    queue_cmd(OP_SEARCH, -32'sd1);
    queue_cmd(OP_FIRST_UNUSED, 32'sh7FFF_FFFF);
    queue_cmd(OP_FIRST_UNUSED + 3'd1, 32'sh8000_0000);
    queue_cmd(OP_FIRST_UNUSED + 3'd2, -32'sd1);
    queue_cmd(OP_PUSH, 32'sh8000_0000);
    queue_cmd(OP_PUSH, 32'sh7FFF_FFFF);
    queue_cmd(OP_PUSH, -32'sd1);
    queue_cmd(OP_PUSH, 32'sd0);
    queue_cmd(OP_PUSH, -32'sd1);
    queue_cmd(OP_LIST, 32'sd0);
    queue_cmd(OP_COUNT, 32'sd0);
    queue_cmd(OP_SEARCH, -32'sd1);
    queue_cmd(OP_SEARCH, 32'sh8000_0000);
    queue_cmd(OP_SEARCH, 32'sd12345);
    queue_cmd(OP_POP, 32'sd0);
    queue_cmd(OP_POP, 32'sd0);
    queue_cmd(OP_SEARCH, -32'sd1);
    drain_all();

    queue_random_traffic(100);
    drain_all();

    send_idle_pct = 50;
    queue_random_traffic(100);
    drain_all();

    // receiver stalls; block fills up and back-pressures the sender
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    queue_random_traffic(100);
    @(posedge clk);
    hold_trigger <= 1'b1;
    @(posedge clk);
    hold_trigger <= 1'b0;
    drain_all();

    send_idle_pct  = 27;
    recv_stall_pct = 27;
    queue_random_traffic(100);
    drain_all();

    repeat (2 * DEPTH + 10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("lifo_stack_with_search_core verification clean");
    end else begin
      $display("lifo_stack_with_search_core verification failed");
    end
    $finish;
  end

endmodule
